### rtl/dba_pkg.sv
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types and codes for the disk block allocator.
// ----------------------------------------------------------------------------
package dba_pkg;

   // Request kinds
   localparam logic [1:0] KIND_RUN    = 2'd0;
   localparam logic [1:0] KIND_INDEX  = 2'd1;
   localparam logic [1:0] KIND_LINKED = 2'd2;

   // Result roles
   localparam logic [1:0] ROLE_RUN   = 2'd0;
   localparam logic [1:0] ROLE_INDEX = 2'd1;
   localparam logic [1:0] ROLE_DATA  = 2'd2;

   // Result status
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   // Width of the next-free pointer
   localparam int PTR_W = 8;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] block_count;
   } req_type;

   typedef struct packed {
      logic [6:0] block_number;
      logic [1:0] role;
      logic       status;
      logic       last;
   } rsp_type;

   // Command from the sequencer to the bitmap scanner
   typedef struct packed {
      logic       start;
      logic       run_mode;   // 1: first-fit run from block 0, 0: next-fit single block
      logic [5:0] count;      // run length in run mode
   } scan_cmd_type;

   // Status from the bitmap scanner
   typedef struct packed {
      logic ready;
      logic done;
      logic found;
   } scan_sts_type;

endpackage

### rtl/dba_ram.sv
// ----------------------------------------------------------------------------
// dba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/dba_scan.sv
// ----------------------------------------------------------------------------
// dba_scan
// Free bitmap owner: clearing pass after reset, one-position-a-cycle scan
// for a free run or a single free block, and the marking pass.
// ----------------------------------------------------------------------------
module dba_scan #(
   parameter int NUM_BLOCKS = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dba_pkg::scan_cmd_type             cmd,
   input  logic [dba_pkg::PTR_W-1:0]         from,
   output dba_pkg::scan_sts_type             sts,
   output logic [$clog2(NUM_BLOCKS)-1:0]     blk
);

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int IW = $clog2(NUM_BLOCKS + 1);
   localparam int SW = (IW > dba_pkg::PTR_W) ? IW : dba_pkg::PTR_W;
   localparam logic [SW-1:0] N_SW   = SW'(NUM_BLOCKS);
   localparam logic [AW-1:0] LAST_A = AW'(NUM_BLOCKS - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_MARK  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic          chk_valid_ff;
   logic [AW-1:0] chk_addr_ff;
   logic [5:0]    run_ff, run_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [AW-1:0] mark_ff, mark_in;
   logic [AW-1:0] end_ff, end_in;
   logic [AW-1:0] start_ff, start_in;
   logic          done_ff, done_in;
   logic          found_ff, found_in;

   logic          issue;
   logic          wr_en;
   logic          wr_bit;
   logic [0:0]    rd_bit;
   logic [6:0]    run_sum;
   logic          hit;
   logic [SW-1:0] run_start;

   // bitmap storage, one bit per block, 1 = free
   dba_ram #(
      .WIDTH (1),
      .DEPTH (NUM_BLOCKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (mark_ff),
      .wr_data (wr_bit),
      .rd_en   (issue),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_bit)
   );

   // read issue and run tracking
   assign issue     = (state_ff == S_SCAN) && (scan_ff < N_SW);
   assign run_sum   = {1'b0, run_ff} + 7'd1;
   assign hit       = chk_valid_ff && rd_bit[0] && (run_sum == {1'b0, cnt_ff});
   assign run_start = SW'(chk_addr_ff) - SW'(cnt_ff) + SW'(1);

   // sequencer
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      mark_in  = mark_ff;
      end_in   = end_ff;
      start_in = start_ff;
      done_in  = 1'b0;
      found_in = found_ff;
      wr_en    = 1'b0;
      wr_bit   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_bit  = 1'b1;
            mark_in = mark_ff + AW'(1);
            if (mark_ff == LAST_A) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.start) begin
               state_in = S_SCAN;
               run_in   = '0;
               if (cmd.run_mode) begin
                  scan_in = '0;
                  cnt_in  = cmd.count;
               end else begin
                  scan_in = SW'(from);
                  cnt_in  = 6'd1;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + SW'(1);
            end
            if (chk_valid_ff) begin
               run_in = rd_bit[0] ? run_sum[5:0] : 6'd0;
            end
            if (hit) begin
               state_in = S_MARK;
               mark_in  = run_start[AW-1:0];
               start_in = run_start[AW-1:0];
               end_in   = chk_addr_ff;
            end else if (!chk_valid_ff && !issue) begin
               // every position from the start point to the last block looked at, nothing fits
               state_in = S_IDLE;
               done_in  = 1'b1;
               found_in = 1'b0;
            end
         end
         S_MARK: begin
            wr_en   = 1'b1;
            wr_bit  = 1'b0;
            mark_in = mark_ff + AW'(1);
            if (mark_ff == end_ff) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
               found_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mark_ff      <= '0;
         chk_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_ff      <= mark_in;
         chk_valid_ff <= issue;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      chk_addr_ff <= scan_ff[AW-1:0];
      run_ff      <= run_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      start_ff    <= start_in;
      found_ff    <= found_in;
   end

   assign sts.ready = (state_ff == S_IDLE);
   assign sts.done  = done_ff;
   assign sts.found = found_ff;
   assign blk       = start_ff;

endmodule

### rtl/disk_block_allocator.sv
// ----------------------------------------------------------------------------
// disk_block_allocator
// Free bitmap block allocator: first-fit runs, next-fit indexed and linked.
// ----------------------------------------------------------------------------
// After reset the bitmap is cleared; requests stall until the clear is done.
// One request at a time. A contiguous request scans from block 0 to the end
// of the first free run, then marks the run; each indexed/linked block is
// scanned for from the pointer, marked, and handed out with its own result
// handshake. Scans read one bitmap position per cycle: a contiguous request
// looks at up to NUM_BLOCKS positions, an indexed/linked one at most NUM_BLOCKS in all.
// ----------------------------------------------------------------------------
module disk_block_allocator #(
   parameter int NUM_BLOCKS = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dba_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int IW = $clog2(NUM_BLOCKS + 1);
   localparam int SW = (IW > dba_pkg::PTR_W) ? IW : dba_pkg::PTR_W;

   localparam logic [1:0] T_IDLE   = 2'd0;
   localparam logic [1:0] T_SEARCH = 2'd1;
   localparam logic [1:0] T_OUT    = 2'd2;

   logic [1:0]                 tstate_ff, tstate_in;
   logic                       run_mode_ff, run_mode_in;
   logic                       idx_ff, idx_in;
   logic [5:0]                 rem_ff, rem_in;
   logic                       more_ff, more_in;
   logic [dba_pkg::PTR_W-1:0]  next_free_ff, next_free_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   dba_pkg::rsp_type           rsp_ff, rsp_in;

   dba_pkg::scan_cmd_type      cmd;
   dba_pkg::scan_sts_type      sts;
   logic [AW-1:0]              blk;
   logic [SW-1:0]              blk_ext;
   logic [SW-1:0]              blk_inc;
   logic                       req_acc;
   logic                       rsp_acc;
   logic                       data_last;

   dba_scan #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .from  (next_free_ff),
      .sts   (sts),
      .blk   (blk)
   );

   // handshakes
   assign req_stall = !((tstate_ff == T_IDLE) && sts.ready);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid_ff && !rsp_stall;
   assign blk_ext   = SW'(blk);
   assign blk_inc   = blk_ext + SW'(1);
   assign data_last = idx_ff ? (rem_ff == 6'd0) : (rem_ff == 6'd1);

   // request sequencer
   always_comb begin
      tstate_in    = tstate_ff;
      run_mode_in  = run_mode_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      more_in      = more_ff;
      next_free_in = next_free_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cmd.start    = 1'b0;
      cmd.run_mode = run_mode_ff;
      cmd.count    = rem_ff;
      unique case (tstate_ff)
         T_IDLE: begin
            if (req_acc) begin
               rem_in = req_data.block_count;
               case (req_data.kind)
                  dba_pkg::KIND_RUN: begin
                     run_mode_in = 1'b1;
                     if (req_data.block_count == 6'd0) begin
                        // empty run: start 0, nothing taken
                        rsp_in.block_number = 7'd0;
                        rsp_in.role         = dba_pkg::ROLE_RUN;
                        rsp_in.status       = dba_pkg::STATUS_OK;
                        rsp_in.last         = 1'b1;
                        rsp_valid_in        = 1'b1;
                        more_in             = 1'b0;
                        tstate_in           = T_OUT;
                     end else begin
                        cmd.start    = 1'b1;
                        cmd.run_mode = 1'b1;
                        cmd.count    = req_data.block_count;
                        tstate_in    = T_SEARCH;
                     end
                  end
                  dba_pkg::KIND_INDEX: begin
                     run_mode_in  = 1'b0;
                     idx_in       = 1'b1;
                     cmd.start    = 1'b1;
                     cmd.run_mode = 1'b0;
                     tstate_in    = T_SEARCH;
                  end
                  dba_pkg::KIND_LINKED: begin
                     run_mode_in = 1'b0;
                     idx_in      = 1'b0;
                     if (req_data.block_count != 6'd0) begin
                        cmd.start    = 1'b1;
                        cmd.run_mode = 1'b0;
                        tstate_in    = T_SEARCH;
                     end
                  end
                  default: begin
                     // unused kind: dropped
                  end
               endcase
            end
         end
         T_SEARCH: begin
            if (sts.done) begin
               rsp_valid_in = 1'b1;
               tstate_in    = T_OUT;
               if (run_mode_ff) begin
                  rsp_in.block_number = sts.found ? blk_ext[6:0] : 7'd0;
                  rsp_in.role         = dba_pkg::ROLE_RUN;
                  rsp_in.status       = sts.found ? dba_pkg::STATUS_OK
                                                  : dba_pkg::STATUS_NO_SPACE;
                  rsp_in.last         = 1'b1;
                  more_in             = 1'b0;
               end else begin
                  rsp_in.role = idx_ff ? dba_pkg::ROLE_INDEX : dba_pkg::ROLE_DATA;
                  if (sts.found) begin
                     next_free_in        = blk_inc[dba_pkg::PTR_W-1:0];
                     rsp_in.block_number = blk_ext[6:0];
                     rsp_in.status       = dba_pkg::STATUS_OK;
                     rsp_in.last         = data_last;
                     more_in             = !data_last;
                     idx_in              = 1'b0;
                     if (!idx_ff) begin
                        rem_in = rem_ff - 6'd1;
                     end
                  end else begin
                     rsp_in.block_number = 7'd0;
                     rsp_in.status       = dba_pkg::STATUS_NO_SPACE;
                     rsp_in.last         = 1'b1;
                     more_in             = 1'b0;
                  end
               end
            end
         end
         T_OUT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (more_ff) begin
                  cmd.start    = 1'b1;
                  cmd.run_mode = 1'b0;
                  tstate_in    = T_SEARCH;
               end else begin
                  tstate_in = T_IDLE;
               end
            end
         end
         default: begin
            tstate_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tstate_ff    <= T_IDLE;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
         run_mode_ff  <= 1'b0;
         idx_ff       <= 1'b0;
         more_ff      <= 1'b0;
         rem_ff       <= '0;
      end else begin
         tstate_ff    <= tstate_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
         run_mode_ff  <= run_mode_in;
         idx_ff       <= idx_in;
         more_ff      <= more_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_req_only_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> !rsp_valid_ff)
      else $error("request accepted while a result is pending");

   a_no_space_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == dba_pkg::STATUS_NO_SPACE)) |-> rsp_ff.last)
      else $error("no-space result not marked last");

   a_run_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.role == dba_pkg::ROLE_RUN)) |-> rsp_ff.last)
      else $error("run result not marked last");

   a_scan_done_out_free: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (!rsp_valid_ff && (tstate_ff == T_SEARCH)))
      else $error("scan finished while output busy");

endmodule
